>>> rtl/cau_pkg.sv
// Package: widths, command codes, payload types and saturation helper for the complex ALU.
package cau_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int DATA_W     = 16;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int MAG_W      = PROD_W;
  localparam int NUM_W      = MAG_W + FRAC_BITS;
  localparam int DEN_W      = PROD_W;
  localparam int Q_W        = DATA_W;
  localparam int REM_W      = DEN_W + Q_W;
  localparam int DIV_STAGES = Q_W;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_EQ  = 3'd4,
    CMD_NE  = 3'd5
  } cmd_t;

  typedef struct packed {
    logic [2:0]               cmd;
    logic signed [DATA_W-1:0] a_re;
    logic signed [DATA_W-1:0] a_im;
    logic signed [DATA_W-1:0] b_re;
    logic signed [DATA_W-1:0] b_im;
  } cau_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] res_re;
    logic signed [DATA_W-1:0] res_im;
    logic                     cmp_true;
    logic                     saturated;
    logic                     div_zero;
  } cau_out_t;

  typedef struct packed {
    logic                     sat;
    logic signed [DATA_W-1:0] val;
  } clip_t;

  // Side information travelling alongside the divider
  typedef struct packed {
    cau_out_t res;
    logic     div_go;
    logic     neg_re;
    logic     neg_im;
    logic     ovf_re;
    logic     ovf_im;
  } side_t;

  function automatic clip_t clip16(input logic signed [SUM_W-1:0] v);
    clip_t c;
    c.sat = 1'b0;
    c.val = DATA_W'(v);
    if (v > SUM_W'(signed'((2 ** (DATA_W - 1)) - 1))) begin
      c.sat = 1'b1;
      c.val = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (v < -SUM_W'(signed'(2 ** (DATA_W - 1)))) begin
      c.sat = 1'b1;
      c.val = {1'b1, {(DATA_W-1){1'b0}}};
    end
    return c;
  endfunction

endpackage

>>> rtl/complex_arith_unit_core.sv
// Top level: pipelined complex-number ALU (add, sub, mul, div, compare) on signed Q8.8.
// Pipeline: 20 register stages, the same depth for every command.
// Throughput: one transaction per cycle; busy is held low, the 16-stage divider sets depth.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset (rst_n, synchronous, active low) clears the valid bits only; no state is kept.
module complex_arith_unit_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cau_pkg::cau_in_t  in_data,
  output logic              out_valid,
  output cau_pkg::cau_out_t out_data
);
  import cau_pkg::*;

  // Pure feed-forward pipeline: never refuses a transaction
  assign busy = 1'b0;

  // ---------------- stage 1: operands and the six products ----------------
  logic                     v1_r;
  cau_in_t                  op_r;
  logic signed [PROD_W-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_bb_r_r, p_bb_i_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= in_data;
    p_rr_r   <= PROD_W'(in_data.a_re) * PROD_W'(in_data.b_re);
    p_ii_r   <= PROD_W'(in_data.a_im) * PROD_W'(in_data.b_im);
    p_ri_r   <= PROD_W'(in_data.a_re) * PROD_W'(in_data.b_im);
    p_ir_r   <= PROD_W'(in_data.a_im) * PROD_W'(in_data.b_re);
    p_bb_r_r <= PROD_W'(in_data.b_re) * PROD_W'(in_data.b_re);
    p_bb_i_r <= PROD_W'(in_data.b_im) * PROD_W'(in_data.b_im);
  end

  // ---------------- stage 2: sums, clipping, divider operands ----------------
  logic                    v2_r;
  cau_out_t                res2_nxt, res2_r;
  logic                    divgo2_nxt, divgo2_r;
  logic signed [SUM_W-1:0] nre_r, nim_r;
  logic [DEN_W-1:0]        den2_nxt, den2_r;

  logic signed [SUM_W-1:0] s_re, s_im;
  clip_t                   c_re, c_im;

  always_comb begin
    den2_nxt   = DEN_W'(p_bb_r_r) + DEN_W'(p_bb_i_r);
    divgo2_nxt = 1'b0;
    res2_nxt   = '0;
    s_re       = '0;
    s_im       = '0;
    case (op_r.cmd)
      CMD_ADD: begin
        s_re = SUM_W'(op_r.a_re) + SUM_W'(op_r.b_re);
        s_im = SUM_W'(op_r.a_im) + SUM_W'(op_r.b_im);
      end
      CMD_SUB: begin
        s_re = SUM_W'(op_r.a_re) - SUM_W'(op_r.b_re);
        s_im = SUM_W'(op_r.a_im) - SUM_W'(op_r.b_im);
      end
      CMD_MUL: begin
        // arithmetic shift rounds toward minus infinity
        s_re = (SUM_W'(p_rr_r) - SUM_W'(p_ii_r)) >>> FRAC_BITS;
        s_im = (SUM_W'(p_ri_r) + SUM_W'(p_ir_r)) >>> FRAC_BITS;
      end
      default: begin
      end
    endcase
    c_re = clip16(s_re);
    c_im = clip16(s_im);
    case (op_r.cmd)
      CMD_ADD, CMD_SUB, CMD_MUL: begin
        res2_nxt.res_re    = c_re.val;
        res2_nxt.res_im    = c_im.val;
        res2_nxt.saturated = c_re.sat | c_im.sat;
      end
      CMD_DIV: begin
        if (den2_nxt == '0) begin
          res2_nxt.div_zero = 1'b1;
        end else begin
          divgo2_nxt = 1'b1;
        end
      end
      CMD_EQ: begin
        res2_nxt.cmp_true = (op_r.a_re == op_r.b_re) && (op_r.a_im == op_r.b_im);
      end
      CMD_NE: begin
        res2_nxt.cmp_true = (op_r.a_re != op_r.b_re) || (op_r.a_im != op_r.b_im);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    res2_r   <= res2_nxt;
    divgo2_r <= divgo2_nxt;
    nre_r    <= SUM_W'(p_rr_r) + SUM_W'(p_ii_r);
    nim_r    <= SUM_W'(p_ir_r) - SUM_W'(p_ri_r);
    den2_r   <= den2_nxt;
  end

  // ---------------- stage 3: magnitudes and overflow check ----------------
  logic             v3_r;
  side_t            side3_nxt, side3_r;
  logic [MAG_W-1:0] mag_re, mag_im;
  logic [NUM_W-1:0] num_re_nxt, num_im_nxt, num_re_r, num_im_r;
  logic [DEN_W-1:0] den3_r;
  logic [REM_W:0]   den_lim;

  always_comb begin
    mag_re     = nre_r[SUM_W-1] ? MAG_W'(-nre_r) : MAG_W'(nre_r);
    mag_im     = nim_r[SUM_W-1] ? MAG_W'(-nim_r) : MAG_W'(nim_r);
    num_re_nxt = {mag_re, {FRAC_BITS{1'b0}}};
    num_im_nxt = {mag_im, {FRAC_BITS{1'b0}}};
    // quotient magnitude of 2^Q_W or more cannot fit the divider
    den_lim    = (REM_W + 1)'(den2_r) << Q_W;
    side3_nxt.res    = res2_r;
    side3_nxt.div_go = divgo2_r;
    side3_nxt.neg_re = nre_r[SUM_W-1];
    side3_nxt.neg_im = nim_r[SUM_W-1];
    side3_nxt.ovf_re = (REM_W + 1)'(num_re_nxt) >= den_lim;
    side3_nxt.ovf_im = (REM_W + 1)'(num_im_nxt) >= den_lim;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    side3_r  <= side3_nxt;
    num_re_r <= num_re_nxt;
    num_im_r <= num_im_nxt;
    den3_r   <= den2_r;
  end

  // ---------------- stages 4..19: two dividers plus matching side pipe ----------------
  logic [Q_W-1:0] quo_re, quo_im;

  cau_div u_div_re (.clk(clk), .num(num_re_r), .den(den3_r), .quo(quo_re));
  cau_div u_div_im (.clk(clk), .num(num_im_r), .den(den3_r), .quo(quo_im));

  logic  vd_r   [DIV_STAGES];
  side_t side_r [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        vd_r[k] <= 1'b0;
      end
    end else begin
      vd_r[0] <= v3_r;
      for (int k = 1; k < DIV_STAGES; k++) begin
        vd_r[k] <= vd_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= side3_r;
    for (int k = 1; k < DIV_STAGES; k++) begin
      side_r[k] <= side_r[k-1];
    end
  end

  // ---------------- final stage: sign, clip and output register ----------------
  side_t    side_last;
  cau_out_t out_nxt;
  clip_t    q_re, q_im;

  function automatic clip_t sign_clip(input logic [Q_W-1:0] q, input logic neg,
                                      input logic ovf);
    clip_t c;
    logic [Q_W:0] qe;
    qe    = (Q_W + 1)'(q);
    c.sat = 1'b0;
    if (neg) begin
      if (ovf || qe > ((Q_W + 1)'(1) << (DATA_W - 1))) begin
        c.sat = 1'b1;
        c.val = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        c.val = DATA_W'(-qe);
      end
    end else begin
      if (ovf || q[Q_W-1]) begin
        c.sat = 1'b1;
        c.val = {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
        c.val = DATA_W'(q);
      end
    end
    return c;
  endfunction

  always_comb begin
    side_last = side_r[DIV_STAGES-1];
    q_re      = sign_clip(quo_re, side_last.neg_re, side_last.ovf_re);
    q_im      = sign_clip(quo_im, side_last.neg_im, side_last.ovf_im);
    out_nxt   = side_last.res;
    if (side_last.div_go) begin
      out_nxt.res_re    = q_re.val;
      out_nxt.res_im    = q_im.val;
      out_nxt.saturated = q_re.sat | q_im.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vd_r[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    out_data <= out_nxt;
  end

endmodule

>>> rtl/cau_div.sv
// Pipelined restoring divider: one quotient bit per register stage.
module cau_div (
  input  logic                       clk,
  input  logic [cau_pkg::NUM_W-1:0]  num,
  input  logic [cau_pkg::DEN_W-1:0]  den,
  output logic [cau_pkg::Q_W-1:0]    quo
);
  import cau_pkg::*;

  logic [REM_W-1:0] rem_r [DIV_STAGES];
  logic [DEN_W-1:0] den_r [DIV_STAGES];
  logic [Q_W-1:0]   quo_r [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    localparam int SH = Q_W - 1 - k;
    logic [REM_W-1:0] rem_in;
    logic [REM_W-1:0] trial;
    logic [DEN_W-1:0] d_in;
    logic [Q_W-1:0]   q_in;

    if (k == 0) begin : g_first
      assign rem_in = REM_W'(num);
      assign d_in   = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign d_in   = den_r[k-1];
      assign q_in   = quo_r[k-1];
    end

    assign trial = REM_W'(d_in) << SH;

    always_ff @(posedge clk) begin
      den_r[k] <= d_in;
      if (rem_in >= trial) begin
        rem_r[k] <= rem_in - trial;
        quo_r[k] <= q_in | (Q_W'(1) << SH);
      end else begin
        rem_r[k] <= rem_in;
        quo_r[k] <= q_in;
      end
    end
  end

  assign quo = quo_r[DIV_STAGES-1];

endmodule

>>> dv/complex_arith_unit_core_chk.sv
// Checker: watches both channels of the complex ALU, predicts each result and compares.
module complex_arith_unit_core_chk (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  cau_pkg::cau_in_t  in_data,
  input  logic              out_valid,
  input  cau_pkg::cau_out_t out_data,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import cau_pkg::*;

  cau_out_t alu_expect_q[$];

  assign pending = alu_expect_q.size();

  function automatic logic signed [15:0] sat16(input longint v, inout logic sat);
    if (v > 32767) begin
      sat = 1'b1;
      return 16'sh7fff;
    end
    if (v < -32768) begin
      sat = 1'b1;
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic cau_out_t alu_predict(input cau_in_t t);
    cau_out_t r;
    longint ar, ai, br, bi, den, nr, ni, pr, pi;
    logic sat;
    ar = t.a_re;
    ai = t.a_im;
    br = t.b_re;
    bi = t.b_im;
    sat = 1'b0;
    r = '0;
    case (t.cmd)
      CMD_ADD: begin
        r.res_re = sat16(ar + br, sat);
        r.res_im = sat16(ai + bi, sat);
      end
      CMD_SUB: begin
        r.res_re = sat16(ar - br, sat);
        r.res_im = sat16(ai - bi, sat);
      end
      CMD_MUL: begin
        // arithmetic shift on longint floors towards minus infinity
        pr = (ar * br - ai * bi) >>> FRAC_BITS;
        pi = (ar * bi + ai * br) >>> FRAC_BITS;
        r.res_re = sat16(pr, sat);
        r.res_im = sat16(pi, sat);
      end
      CMD_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) r.div_zero = 1'b1;
        else begin
          nr = (ar * br + ai * bi) * (64'sd1 <<< FRAC_BITS);
          ni = (ai * br - ar * bi) * (64'sd1 <<< FRAC_BITS);
          r.res_re = sat16(nr / den, sat);
          r.res_im = sat16(ni / den, sat);
        end
      end
      CMD_EQ: r.cmp_true = (ar == br) && (ai == bi);
      CMD_NE: r.cmp_true = (ar != br) || (ai != bi);
      default: ;
    endcase
    r.saturated = sat;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    cau_out_t w;
    if (rst_n && start && !busy) alu_expect_q.push_back(alu_predict(in_data));
    if (rst_n && out_valid) begin
      if (alu_expect_q.size() == 0) report_mismatch("unexpected result", 1, 0);
      else begin
        w = alu_expect_q.pop_front();
        if (out_data.res_re !== w.res_re)
          report_mismatch("res_re", out_data.res_re, w.res_re);
        if (out_data.res_im !== w.res_im)
          report_mismatch("res_im", out_data.res_im, w.res_im);
        if (out_data.cmp_true !== w.cmp_true)
          report_mismatch("cmp_true", out_data.cmp_true, w.cmp_true);
        if (out_data.saturated !== w.saturated)
          report_mismatch("saturated", out_data.saturated, w.saturated);
        if (out_data.div_zero !== w.div_zero)
          report_mismatch("div_zero", out_data.div_zero, w.div_zero);
      end
    end
  end
endmodule

>>> dv/complex_arith_unit_core_tb.sv
// Testbench top: drives complex ALU transactions and gives the verdict.
module complex_arith_unit_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cau_pkg::*;

  localparam int LATENCY     = 20;
  localparam int N_RANDOM    = 430;
  localparam int CYCLE_LIMIT = 200000;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  cau_in_t  in_data;
  logic     out_valid;
  cau_out_t out_data;
  int       fail_count;
  int       pending;
  int       cycles;

  complex_arith_unit_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  complex_arith_unit_core_chk chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: a generous ceiling on the whole run
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("** complex_arith_unit_core: FAILED **");
        $finish;
      end
    end
  end

  // Random operand part: extremes, tiny and small values and full range
  function automatic logic [15:0] rand_part();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($signed($urandom_range(0, 8)) - 4);
      3: return 16'($signed($urandom_range(0, 1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  // One transaction: optional idle gap, then hold start until accepted.
  // Start stays high straight into the next transaction when there is no gap.
  task automatic send_op(input logic [2:0] c, input logic [15:0] ar, input logic [15:0] ai,
                         input logic [15:0] br, input logic [15:0] bi, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start      <= 1'b1;
    in_data    <= '{cmd: c, a_re: ar, a_im: ai, b_re: br, b_im: bi};
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    logic [2:0]  c;
    logic [15:0] ar, ai, br, bi;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: extremes, every command, zero divisor, compares, unused codes
    send_op(CMD_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 0);
    send_op(CMD_ADD, 16'h0100, 16'hff00, 16'h0080, 16'h0001, 0);
    send_op(CMD_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 0);
    send_op(CMD_SUB, 16'h0100, 16'h0200, 16'h0100, 16'h0300, 1);
    send_op(CMD_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
    send_op(CMD_MUL, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 0);
    send_op(CMD_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000, 0); // floors -1/65536 to -1/256
    send_op(CMD_MUL, 16'h0180, 16'hfe80, 16'h0200, 16'h0100, 2);
    send_op(CMD_DIV, 16'h0100, 16'h0000, 16'h0000, 16'h0000, 0); // zero divisor
    send_op(CMD_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000, 0);
    send_op(CMD_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
    send_op(CMD_DIV, 16'hffff, 16'h0001, 16'h0300, 16'hfd00, 0);
    send_op(CMD_DIV, 16'h0100, 16'h0100, 16'h7fff, 16'h7fff, 0);
    send_op(CMD_EQ,  16'h1234, 16'h8000, 16'h1234, 16'h8000, 0);
    send_op(CMD_EQ,  16'h1234, 16'h8000, 16'h1234, 16'h8001, 0);
    send_op(CMD_NE,  16'h7fff, 16'h0000, 16'h7fff, 16'h0000, 0);
    send_op(CMD_NE,  16'h7fff, 16'h0000, 16'h7ffe, 16'h0000, 0);
    send_op(3'd6,    16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0);
    send_op(3'd7,    16'h8000, 16'h8000, 16'h0000, 16'h0000, 0);

    // Hold-off: let the pipeline empty completely before the random part
    drain();

    for (int i = 0; i < N_RANDOM; i++) begin
      c  = (i % 50 < 3) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      ar = rand_part();
      ai = rand_part();
      br = rand_part();
      bi = rand_part();
      if ($urandom_range(0, 9) == 0) begin
        br = '0;
        bi = '0;
      end
      if ((c == CMD_EQ || c == CMD_NE) && $urandom_range(0, 1)) begin
        br = ar;
        bi = ai;
      end
      // every third block of 40 runs back-to-back
      send_op(c, ar, ai, br, bi, ((i / 40) % 3 == 0) ? 0 : $urandom_range(0, 9));
    end

    drain();
    repeat (LATENCY + 5) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** complex_arith_unit_core: PASSED **");
    end else begin
      $display("** complex_arith_unit_core: FAILED **");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/cau_pkg.sv
rtl/cau_div.sv
rtl/complex_arith_unit_core.sv
dv/complex_arith_unit_core_chk.sv
dv/complex_arith_unit_core_tb.sv
